// ===== src/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared sizes, field widths and register indexes of the RC4 cipher core.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

    // permutation table
    localparam int TABLE_SIZE    = 256;
    localparam int PTR_W         = $clog2(TABLE_SIZE);
    localparam int BYTE_W        = 8;

    // key storage
    localparam int KEY_MAX_BYTES = 16;
    localparam int KEY_IDX_W     = $clog2(KEY_MAX_BYTES);
    localparam int KEY_LEN_W     = 5;
    localparam int KEY_WORD_W    = 64;

    // configuration channel
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_LOW  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_HIGH = CFG_IDX_W'(2);

    localparam logic [KEY_LEN_W-1:0] KEY_LENGTH_RESET   = KEY_LEN_W'(16);

endpackage : rc4_pkg

`default_nettype wire

// ===== src/rc4_ifs.sv =====
// ----------------------------------------------------------------------------
// rc4_ifs
// Valid/ready channels of the RC4 core: text requests, result requests and
// configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rc4_in_if import rc4_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              message_start;

    modport source (output valid, output data_byte, output message_start, input ready);
    modport sink   (input valid, input data_byte, input message_start, output ready);
endinterface : rc4_in_if

interface rc4_out_if import rc4_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface : rc4_out_if

interface rc4_cfg_if import rc4_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : rc4_cfg_if

`default_nettype wire

// ===== src/rc4_stream_cipher_core.sv =====
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core
// RC4 encrypt/decrypt, one byte per text request, permutation in one
// synchronous single-read-port table.
// ----------------------------------------------------------------------------
// Channels: 'text' carries a data byte and a message_start mark, 'result'
// returns data_byte XOR keystream, one result per text request, in order.
// 'cfg' writes key_length (index 0), key bytes 0-7 (index 1) and key bytes
// 8-15 (index 2); it is always ready and other indexes are dropped. Write
// configuration only while no request is in flight.
// Throughput is set by the table's single read port: each byte reads S[i],
// then S[j], then S[S[i]+S[j]], and the swap writes overlap these reads.
// A new request is taken in the cycle the previous result is loaded.
// A request on a keyed table steps through ST_P2, ST_P3 and ST_P4, which loads the result.
// A request marked message_start, and the first request after reset, first
// runs the key schedule: ST_FILL writes the identity permutation, then
// ST_KB, ST_KC and ST_KD swap each table entry in turn, before the generator steps run.
// Reset clears indices, the keyed flag and key_length to 16; the table is
// rebuilt by the first schedule. When 'result' stalls, the result register
// holds and the core waits at its last step with the next request pending.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher_core import rc4_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    rc4_cfg_if.sink      cfg,
    rc4_in_if.sink       text,
    rc4_out_if.source    result
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_FILL = 8'b0000_0010,
        ST_KB   = 8'b0000_0100,
        ST_KC   = 8'b0000_1000,
        ST_KD   = 8'b0001_0000,
        ST_P2   = 8'b0010_0000,
        ST_P3   = 8'b0100_0000,
        ST_P4   = 8'b1000_0000
    } state_t;

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(TABLE_SIZE - 1);
    localparam logic [PTR_W-1:0] ONE_PTR  = PTR_W'(1);

    // configuration registers
    logic [KEY_LEN_W-1:0]  key_length_reg;
    logic [KEY_WORD_W-1:0] key_low_reg;
    logic [KEY_WORD_W-1:0] key_high_reg;

    // control and datapath registers
    state_t            state_reg,   state_next;
    logic              keyed_reg,   keyed_next;
    logic [PTR_W-1:0]  i_reg,       i_next;
    logic [PTR_W-1:0]  j_reg,       j_next;
    logic [PTR_W-1:0]  cnt_reg,     cnt_next;
    logic [KEY_IDX_W-1:0] kidx_reg, kidx_next;
    logic [BYTE_W-1:0] si_reg,      si_next;
    logic [PTR_W-1:0]  t_reg,       t_next;
    logic [BYTE_W-1:0] data_reg,    data_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg,  out_byte_next;

    // table ports
    logic [BYTE_W-1:0] perm_mem [TABLE_SIZE];
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [PTR_W-1:0]  rd_addr;
    logic [BYTE_W-1:0] rd_data_reg;
    logic              fwd_reg;
    logic [BYTE_W-1:0] fwd_data_reg;
    logic [BYTE_W-1:0] rd_eff;

    // misc
    logic                  in_accept;
    logic                  out_free;
    logic [KEY_LEN_W-1:0]  len_eff;
    logic [KEY_IDX_W-1:0]  key_last;
    logic [2*KEY_WORD_W-1:0] key_all;
    logic [BYTE_W-1:0]     key_byte;
    logic [BYTE_W-1:0]     ks;

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= KEY_LENGTH_RESET;
            key_low_reg    <= '0;
            key_high_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_KEY_LENGTH:     key_length_reg <= cfg.data[KEY_LEN_W-1:0];
                REG_KEY_BYTES_LOW:  key_low_reg    <= cfg.data;
                REG_KEY_BYTES_HIGH: key_high_reg   <= cfg.data;
                default:            ;
            endcase
        end
    end

    // clamp key length to 1..KEY_MAX_BYTES and pick the current key byte
    always_comb
    begin
        if (key_length_reg == '0)
            len_eff = KEY_LEN_W'(1);
        else if (key_length_reg > KEY_LEN_W'(KEY_MAX_BYTES))
            len_eff = KEY_LEN_W'(KEY_MAX_BYTES);
        else
            len_eff = key_length_reg;
    end

    assign key_last = KEY_IDX_W'(len_eff - KEY_LEN_W'(1));
    assign key_all  = {key_high_reg, key_low_reg};
    assign key_byte = key_all[kidx_reg*BYTE_W +: BYTE_W];

    // table: one write port, one registered read port, write-first forwarding
    always_ff @(posedge clk)
    begin
        if (wr_en)
            perm_mem[wr_addr] <= wr_data;
        rd_data_reg  <= perm_mem[rd_addr];
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_reg <= 1'b0;
        else
            fwd_reg <= wr_en && (wr_addr == rd_addr);
    end

    assign rd_eff = fwd_reg ? fwd_data_reg : rd_data_reg;

    // handshake
    assign out_free      = !out_valid_reg || result.ready;
    assign text.ready    = (state_reg == ST_IDLE) || ((state_reg == ST_P4) && out_free);
    assign in_accept     = text.valid && text.ready;
    assign result.valid  = out_valid_reg;
    assign result.out_byte = out_byte_reg;

    // keystream byte; the pending swap write to S[j] is patched in
    assign ks = (t_reg == j_reg) ? si_reg : rd_eff;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        keyed_next     = keyed_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cnt_next       = cnt_reg;
        kidx_next      = kidx_reg;
        si_next        = si_reg;
        t_next         = t_reg;
        data_next      = data_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_byte_next  = out_byte_reg;
        wr_en          = 1'b0;
        wr_addr        = j_reg;
        wr_data        = si_reg;
        rd_addr        = i_reg + ONE_PTR;

        case (state_reg)
            ST_IDLE: ;
            // write identity permutation
            ST_FILL:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg;
                wr_data = cnt_reg;
                rd_addr = cnt_reg + ONE_PTR;
                cnt_next = cnt_reg + ONE_PTR;
                if (cnt_reg == LAST_PTR)
                    state_next = ST_KB;
            end
            // schedule: take S[n], advance j, read S[j]
            ST_KB:
            begin
                si_next    = rd_eff;
                j_next     = j_reg + rd_eff + key_byte;
                rd_addr    = j_next;
                state_next = ST_KC;
            end
            // schedule: S[n] <= S[j]
            ST_KC:
            begin
                wr_en      = 1'b1;
                wr_addr    = cnt_reg;
                wr_data    = rd_eff;
                state_next = ST_KD;
            end
            // schedule: S[j] <= old S[n], fetch next entry
            ST_KD:
            begin
                wr_en     = 1'b1;
                cnt_next  = cnt_reg + ONE_PTR;
                kidx_next = (kidx_reg == key_last) ? '0 : kidx_reg + KEY_IDX_W'(1);
                if (cnt_reg == LAST_PTR)
                begin
                    rd_addr    = ONE_PTR;
                    j_next     = '0;
                    keyed_next = 1'b1;
                    state_next = ST_P2;
                end
                else
                begin
                    rd_addr    = cnt_reg + ONE_PTR;
                    state_next = ST_KB;
                end
            end
            // generator: take S[i], advance i and j, read S[j]
            ST_P2:
            begin
                si_next    = rd_eff;
                i_next     = i_reg + ONE_PTR;
                j_next     = j_reg + rd_eff;
                rd_addr    = j_next;
                state_next = ST_P3;
            end
            // generator: S[i] <= S[j], read S[S[i]+S[j]]
            ST_P3:
            begin
                wr_en      = 1'b1;
                wr_addr    = i_reg;
                wr_data    = rd_eff;
                t_next     = si_reg + rd_eff;
                rd_addr    = t_next;
                state_next = ST_P4;
            end
            // generator: S[j] <= old S[i], load result; hold the read while stalled
            ST_P4:
            begin
                wr_en = 1'b1;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = data_reg ^ ks;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    rd_addr = t_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // take a new request and pick its path
        if (in_accept)
        begin
            data_next = text.data_byte;
            if (text.message_start || !keyed_reg)
            begin
                state_next = ST_FILL;
                cnt_next   = '0;
                kidx_next  = '0;
                i_next     = '0;
                j_next     = '0;
            end
            else
            begin
                state_next = ST_P2;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            keyed_reg     <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            cnt_reg       <= '0;
            kidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            keyed_reg     <= keyed_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            cnt_reg       <= cnt_next;
            kidx_reg      <= kidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        si_reg       <= si_next;
        t_reg        <= t_next;
        data_reg     <= data_next;
        out_byte_reg <= out_byte_next;
    end

    // checks
    a_accept_path: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_FILL) || (state_reg == ST_P2))
        else $error("accepted request did not start schedule or generator");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_P4) && out_free |=> out_valid_reg)
        else $error("result not loaded at end of generator step");

    a_keyed_holds: assert property (@(posedge clk) disable iff (!rst_n)
        keyed_reg |=> keyed_reg)
        else $error("keyed flag dropped");

    a_gen_keyed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_P2) |-> keyed_reg)
        else $error("generator ran before key schedule");

endmodule : rc4_stream_cipher_core

`default_nettype wire

// ===== bench/tb_rc4_stream_cipher_core.sv =====
// ----------------------------------------------------------------------------
// tb_rc4_stream_cipher_core
// Self-checking bench for the RC4 cipher core. A keystream model inside a
// small scoreboard predicts every result byte from the accepted text
// requests and the configured key. Directed requests cover reset keying,
// key length clamping, ignored register indexes and key changes in the
// middle of a message. Random messages then run under several idle and
// stall mixes, with one long result stall that backs up the text channel.
// ----------------------------------------------------------------------------

module tb_rc4_stream_cipher_core import rc4_pkg::*;
();

    localparam int    CLK_PERIOD   = 8;
    localparam longint LIMIT_CYCLES = 5_000_000;
    localparam int    LONG_HOLD    = 300;
    localparam int    PHASE_ITEMS  = 92;
    localparam int    MAX_PRINTED  = 50;

    // indexes outside the register list, writes to them are dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

    // ------------------------------------------------------------------------
    // Keystream scoreboard: keeps its own permutation, indices and key, and
    // the queue of output bytes still owed by the core.
    // ------------------------------------------------------------------------
    class rc4_keystream_board;
        logic [BYTE_W-1:0]     perm [TABLE_SIZE];
        logic [BYTE_W-1:0]     idx_i;
        logic [BYTE_W-1:0]     idx_j;
        bit                    keyed;
        logic [KEY_LEN_W-1:0]  key_len;
        logic [KEY_WORD_W-1:0] key_lo;
        logic [KEY_WORD_W-1:0] key_hi;
        logic [BYTE_W-1:0]     owed_bytes [$];
        int                    fails;

        function new();
            idx_i   = '0;
            idx_j   = '0;
            keyed   = 1'b0;
            key_len = KEY_LENGTH_RESET;
            key_lo  = '0;
            key_hi  = '0;
            fails   = 0;
        endfunction

        function void note_config(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_KEY_LENGTH:     key_len = val[KEY_LEN_W-1:0];
                REG_KEY_BYTES_LOW:  key_lo  = val;
                REG_KEY_BYTES_HIGH: key_hi  = val;
                default: ;
            endcase
        endfunction

        function logic [BYTE_W-1:0] key_byte(input int n);
            int b;
            b = n % KEY_MAX_BYTES;
            if (b < 8)
                return key_lo[(b % 8) * 8 +: 8];
            return key_hi[(b % 8) * 8 +: 8];
        endfunction

        // rebuild the permutation from the current key, clear both indices
        function void run_key_schedule();
            int                len;
            logic [BYTE_W-1:0] j;
            logic [BYTE_W-1:0] t;
            len = int'(key_len);
            if (len == 0)
                len = 1;
            if (len > KEY_MAX_BYTES)
                len = KEY_MAX_BYTES;
            for (int n = 0; n < TABLE_SIZE; n++)
                perm[n] = BYTE_W'(n);
            j = '0;
            for (int n = 0; n < TABLE_SIZE; n++)
            begin
                j       = j + perm[n] + key_byte(n % len);
                t       = perm[n];
                perm[n] = perm[j];
                perm[j] = t;
            end
            idx_i = '0;
            idx_j = '0;
            keyed = 1'b1;
        endfunction

        // advance the generator once and queue the output byte
        function void note_request(input logic [BYTE_W-1:0] data, input logic mark);
            logic [BYTE_W-1:0] t;
            logic [BYTE_W-1:0] sum;
            if (mark || !keyed)
                run_key_schedule();
            idx_i       = idx_i + 1'b1;
            idx_j       = idx_j + perm[idx_i];
            t           = perm[idx_i];
            perm[idx_i] = perm[idx_j];
            perm[idx_j] = t;
            sum         = perm[idx_i] + perm[idx_j];
            owed_bytes.push_back(data ^ perm[sum]);
        endfunction

        task report(input string what);
            fails++;
            if (fails <= MAX_PRINTED)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(input logic [BYTE_W-1:0] got);
            logic [BYTE_W-1:0] want;
            if (owed_bytes.size() == 0)
            begin
                report($sformatf("out_byte 0x%02h with no request outstanding", got));
                return;
            end
            want = owed_bytes.pop_front();
            if (got !== want)
                report($sformatf("out_byte 0x%02h, predicted 0x%02h", got, want));
        endtask

        function int pending();
            return owed_bytes.size();
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rc4_cfg_if  cfg_ch ();
    rc4_in_if   text_ch ();
    rc4_out_if  result_ch ();

    rc4_keystream_board board;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    rc4_stream_cipher_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .text   (text_ch),
        .result (result_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------

    // offer one text request, idling at random first
    task offer_byte(input logic [BYTE_W-1:0] data, input logic mark);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            text_ch.valid <= 1'b0;
            @(negedge clk);
        end
        text_ch.valid         <= 1'b1;
        text_ch.data_byte     <= data;
        text_ch.message_start <= mark;
        do
            @(posedge clk);
        while (!text_ch.ready);
        board.note_request(data, mark);
    endtask

    task text_idle();
        @(negedge clk);
        text_ch.valid <= 1'b0;
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        board.note_config(idx, val);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // wait until every owed result is back, then let the core go quiet
    task settle();
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // new key with a length drawn mostly from the extremes
    task load_random_key();
        logic [CFG_DATA_W-1:0] len_word;
        len_word = {$urandom, $urandom};
        case ($urandom_range(5))
            0: len_word[KEY_LEN_W-1:0] = '0;
            1: len_word[KEY_LEN_W-1:0] = KEY_LEN_W'(1);
            2: len_word[KEY_LEN_W-1:0] = KEY_LEN_W'(KEY_MAX_BYTES);
            3: len_word[KEY_LEN_W-1:0] = '1;
            default: len_word[KEY_LEN_W-1:0] = KEY_LEN_W'($urandom_range(31));
        endcase
        write_reg(REG_KEY_LENGTH, len_word);
        write_reg(REG_KEY_BYTES_LOW, {$urandom, $urandom});
        write_reg(REG_KEY_BYTES_HIGH, {$urandom, $urandom});
        if ($urandom_range(2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LAST, REG_UNUSED_FIRST)),
                      {$urandom, $urandom});
    endtask

    // random messages, mostly short; resume continues the previous message
    task run_phase(input int n_items, input bit resume);
        int sent;
        int msg_len;
        logic mark;
        sent = 0;
        while (sent < n_items)
        begin
            msg_len = ($urandom_range(9) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 25);
            for (int k = 0; k < msg_len && sent < n_items; k++)
            begin
                if (k == 0)
                    mark = !(resume && sent == 0);
                else
                    mark = ($urandom_range(39) == 0);
                offer_byte(BYTE_W'($urandom), mark);
                sent++;
            end
        end
        text_idle();
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall at random, or hold off for a counted stretch
    // ------------------------------------------------------------------------
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                board.check_result(result_ch.out_byte);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        board                 = new();
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;
        text_ch.valid         = 1'b0;
        text_ch.data_byte     = '0;
        text_ch.message_start = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset key; the first request keys the table even without its mark
        offer_byte(8'h00, 1'b0);
        offer_byte(8'hFF, 1'b0);
        offer_byte(8'h5A, 1'b0);
        offer_byte(8'h00, 1'b1);
        offer_byte(8'hFF, 1'b1);
        text_idle();
        settle();

        // zero length field under junk upper bits, plus dropped indexes
        write_reg(REG_KEY_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0);
        write_reg(REG_KEY_BYTES_LOW, '1);
        write_reg(REG_KEY_BYTES_HIGH, 64'h0123_4567_89AB_CDEF);
        write_reg(REG_UNUSED_FIRST, 64'h1F);
        write_reg(REG_UNUSED_LAST, '0);
        offer_byte(8'h00, 1'b1);
        offer_byte(8'hFF, 1'b0);
        offer_byte(8'h80, 1'b0);
        offer_byte(8'h01, 1'b0);
        text_idle();
        settle();

        // length above the maximum clamps to a full key
        write_reg(REG_KEY_LENGTH, 64'd31);
        offer_byte(8'hC3, 1'b1);
        offer_byte(8'h3C, 1'b0);
        offer_byte(8'h7E, 1'b0);
        offer_byte(8'hE7, 1'b0);
        text_idle();
        settle();

        // key change mid-message only lands at the next schedule
        write_reg(REG_KEY_LENGTH, 64'd1);
        write_reg(REG_KEY_BYTES_LOW, 64'h80);
        offer_byte(8'h3C, 1'b0);
        offer_byte(8'h00, 1'b1);
        offer_byte(8'hFF, 1'b0);
        text_idle();
        settle();

        write_reg(REG_KEY_LENGTH, 64'd16);
        write_reg(REG_KEY_BYTES_HIGH, '1);
        offer_byte(8'hA5, 1'b1);
        offer_byte(8'h5A, 1'b0);
        text_idle();
        settle();

        // random phases over the idle and stall mixes
        for (int p = 0; p < 8; p++)
        begin
            load_random_key();
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 63;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 63;
                end
                default:
                begin
                    send_idle_pct  = 27;
                    recv_stall_pct = 27;
                end
            endcase
            // back up the core while requests keep coming
            if (p == 0)
                hold_left = LONG_HOLD;
            run_phase(PHASE_ITEMS, (p % 2) == 1);
            settle();
        end

        repeat (8) @(posedge clk);
        if (board.pending() != 0)
            board.report($sformatf("%0d results never arrived", board.pending()));
        if (board.fails == 0)
            $display("[rc4_stream_cipher_core] OK");
        else
            $display("[rc4_stream_cipher_core] ERROR");
        $finish;
    end

    // hard stop if the core hangs
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("[rc4_stream_cipher_core] ERROR");
        $finish;
    end

endmodule : tb_rc4_stream_cipher_core

// ===== rc4_stream_cipher_core.f =====
src/rc4_pkg.sv
src/rc4_ifs.sv
src/rc4_stream_cipher_core.sv
bench/tb_rc4_stream_cipher_core.sv
